>>> rtl/wfa_pkg.sv
// wfa_pkg: shared constants, types and datapath command codes for the
// worst-fit extent allocator. No dependencies.
`timescale 1ns / 1ps
package wfa_pkg;

	localparam int MAX_EXTENTS  = 64;
	localparam int IDX_W        = $clog2(MAX_EXTENTS);
	localparam int CNT_W        = $clog2(MAX_EXTENTS + 1);
	localparam int HEAP_UNITS   = 65536;
	localparam int ADDR_W       = 16;
	localparam int SIZE_W       = 17;
	localparam int REQ_W        = 20;
	localparam int UNIT_BYTES   = 16;
	localparam int UNIT_SHIFT   = $clog2(UNIT_BYTES);
	localparam int GROW_DEFAULT = 1024;
	localparam int CFG_W        = 17;
	localparam int CFG_IDX_W    = 1;
	localparam int ST_W         = 2;
	localparam int ENT_W        = ADDR_W + SIZE_W;

	localparam logic [ST_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [ST_W-1:0] STATUS_OOM  = 2'd1;
	localparam logic [ST_W-1:0] STATUS_FULL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GROW_MIN   = 1'b1;

	localparam int CMD_W = 5;
	localparam logic [CMD_W-1:0] CMD_NOP         = 5'd0;
	localparam logic [CMD_W-1:0] CMD_ACCEPT      = 5'd1;
	localparam logic [CMD_W-1:0] CMD_RES_OK      = 5'd2;
	localparam logic [CMD_W-1:0] CMD_ISTART      = 5'd3;
	localparam logic [CMD_W-1:0] CMD_WSTART      = 5'd4;
	localparam logic [CMD_W-1:0] CMD_WSCAN       = 5'd5;
	localparam logic [CMD_W-1:0] CMD_ISCAN       = 5'd6;
	localparam logic [CMD_W-1:0] CMD_SHIFT       = 5'd7;
	localparam logic [CMD_W-1:0] CMD_TAKE_EXACT  = 5'd8;
	localparam logic [CMD_W-1:0] CMD_TAKE_CUT    = 5'd9;
	localparam logic [CMD_W-1:0] CMD_OOM         = 5'd10;
	localparam logic [CMD_W-1:0] CMD_GSTART      = 5'd11;
	localparam logic [CMD_W-1:0] CMD_MERGE_BOTH  = 5'd12;
	localparam logic [CMD_W-1:0] CMD_MERGE_PREV  = 5'd13;
	localparam logic [CMD_W-1:0] CMD_MERGE_NEXT  = 5'd14;
	localparam logic [CMD_W-1:0] CMD_FULL        = 5'd15;
	localparam logic [CMD_W-1:0] CMD_UP_START    = 5'd16;
	localparam logic [CMD_W-1:0] CMD_UP_FIN      = 5'd17;
	localparam logic [CMD_W-1:0] CMD_RM_FIN      = 5'd18;
	localparam logic [CMD_W-1:0] CMD_GROW_COMMIT = 5'd19;
	localparam logic [CMD_W-1:0] CMD_PUBLISH     = 5'd20;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
	} ent_t;

	typedef struct packed {
		logic [CMD_W-1:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic op_free;
		logic free_ok;
		logic scan_done;
		logic ins_done;
		logic found;
		logic exact;
		logic grow_fail;
		logic ovl;
		logic mp;
		logic mn;
		logic full;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/wfa_ram.sv
// wfa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module wfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/wfa_ctrl.sv
// wfa_ctrl: sequencing state machine of the allocator; issues one datapath
// command per cycle. Depends on wfa_pkg.
`timescale 1ns / 1ps
module wfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output wfa_pkg::dp_cmd_t  cmd,
	input  wfa_pkg::dp_stat_t stat
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_WSCAN    = 4'd2;
	localparam logic [3:0] S_WDEC     = 4'd3;
	localparam logic [3:0] S_ISCAN    = 4'd4;
	localparam logic [3:0] S_IDEC     = 4'd5;
	localparam logic [3:0] S_SHIFT_DN = 4'd6;
	localparam logic [3:0] S_RMFIN    = 4'd7;
	localparam logic [3:0] S_SHIFT_UP = 4'd8;
	localparam logic [3:0] S_UPFIN    = 4'd9;
	localparam logic [3:0] S_IFIN     = 4'd10;
	localparam logic [3:0] S_OUT      = 4'd11;

	logic [3:0] state_q, state_d;
	logic       take_q, take_d;

	always_comb begin
		state_d  = state_q;
		take_d   = take_q;
		cmd.code = wfa_pkg::CMD_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = wfa_pkg::CMD_ACCEPT;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.op_free) begin
					if (stat.free_ok) begin
						cmd.code = wfa_pkg::CMD_ISTART;
						state_d  = S_ISCAN;
					end else begin
						cmd.code = wfa_pkg::CMD_RES_OK;
						state_d  = S_OUT;
					end
				end else begin
					cmd.code = wfa_pkg::CMD_WSTART;
					state_d  = S_WSCAN;
				end
			end
			S_WSCAN: begin
				cmd.code = wfa_pkg::CMD_WSCAN;
				if (stat.scan_done) state_d = S_WDEC;
			end
			S_WDEC: begin
				if (stat.found) begin
					if (stat.exact) begin
						cmd.code = wfa_pkg::CMD_TAKE_EXACT;
						take_d   = 1'b1;
						state_d  = S_SHIFT_DN;
					end else begin
						cmd.code = wfa_pkg::CMD_TAKE_CUT;
						state_d  = S_OUT;
					end
				end else if (stat.grow_fail) begin
					cmd.code = wfa_pkg::CMD_OOM;
					state_d  = S_OUT;
				end else begin
					cmd.code = wfa_pkg::CMD_GSTART;
					state_d  = S_ISCAN;
				end
			end
			S_ISCAN: begin
				cmd.code = wfa_pkg::CMD_ISCAN;
				if (stat.ins_done) state_d = S_IDEC;
			end
			S_IDEC: begin
				if (stat.ovl) begin
					state_d = S_IFIN;
				end else if (stat.mp && stat.mn) begin
					cmd.code = wfa_pkg::CMD_MERGE_BOTH;
					take_d   = 1'b0;
					state_d  = S_SHIFT_DN;
				end else if (stat.mp) begin
					cmd.code = wfa_pkg::CMD_MERGE_PREV;
					state_d  = S_IFIN;
				end else if (stat.mn) begin
					cmd.code = wfa_pkg::CMD_MERGE_NEXT;
					state_d  = S_IFIN;
				end else if (stat.full) begin
					cmd.code = wfa_pkg::CMD_FULL;
					state_d  = S_OUT;
				end else begin
					cmd.code = wfa_pkg::CMD_UP_START;
					state_d  = S_SHIFT_UP;
				end
			end
			S_SHIFT_DN: begin
				cmd.code = wfa_pkg::CMD_SHIFT;
				if (stat.scan_done) state_d = S_RMFIN;
			end
			S_RMFIN: begin
				cmd.code = wfa_pkg::CMD_RM_FIN;
				state_d  = take_q ? S_OUT : S_IFIN;
			end
			S_SHIFT_UP: begin
				cmd.code = wfa_pkg::CMD_SHIFT;
				if (stat.scan_done) state_d = S_UPFIN;
			end
			S_UPFIN: begin
				cmd.code = wfa_pkg::CMD_UP_FIN;
				state_d  = S_IFIN;
			end
			S_IFIN: begin
				if (stat.op_free) begin
					cmd.code = wfa_pkg::CMD_RES_OK;
					state_d  = S_OUT;
				end else begin
					cmd.code = wfa_pkg::CMD_GROW_COMMIT;
					state_d  = S_WSCAN;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.code = wfa_pkg::CMD_PUBLISH;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			take_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			take_q  <= take_d;
		end
	end

	// a beat is taken only from idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == wfa_pkg::CMD_ACCEPT) |-> (state_q == S_IDLE))
		else $error("accept outside idle");
	// after an accept the next cycle decodes
	a_decode_next: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == wfa_pkg::CMD_ACCEPT) |=> (state_q == S_DECODE))
		else $error("decode did not follow accept");
	// a result is published only when the output register can take it
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == wfa_pkg::CMD_PUBLISH) |-> stat.out_free)
		else $error("publish onto a held result");

endmodule

>>> rtl/wfa_dpath.sv
// wfa_dpath: extent table RAM, scan/shift pipeline, heap registers and the
// result registers. Depends on wfa_pkg and wfa_ram.
`timescale 1ns / 1ps
module wfa_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [wfa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wfa_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 op,
	input  logic [wfa_pkg::REQ_W-1:0]            request_bytes,
	input  logic [wfa_pkg::ADDR_W-1:0]           free_address,
	input  logic [wfa_pkg::SIZE_W-1:0]           free_units,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output logic [wfa_pkg::ADDR_W-1:0]           payload_address,
	output logic [wfa_pkg::ST_W-1:0]             status,
	input  wfa_pkg::dp_cmd_t                     cmd,
	output wfa_pkg::dp_stat_t                    stat
);

	localparam int IW = wfa_pkg::IDX_W;
	localparam int CW = wfa_pkg::CNT_W;
	localparam int SW = wfa_pkg::SIZE_W;
	localparam int AW = wfa_pkg::ADDR_W;

	// control state
	logic [SW-1:0] lim_q, grow_q, top_q;
	logic [CW-1:0] cnt_q, rem_q;
	logic [IW-1:0] rover_q;
	logic          op_q, free_ok_q, found_q, pv_valid_q, nx_valid_q, stop_q;
	logic          shift_up_q, rv_s1, out_valid_q;

	// payload
	logic [SW-1:0] n_q, u_q, best_sz_q;
	logic [AW-1:0] h_q, best_start_q, res_pay_q, out_pay_q;
	logic [IW-1:0] best_idx_q, src_q, idx_s1;
	logic [CW-1:0] ins_i_q, tgt_q;
	wfa_pkg::ent_t pv_q, nx_q;
	logic [wfa_pkg::ST_W-1:0] res_st_q, out_st_q;

	// RAM port
	logic                     ram_we;
	logic [IW-1:0]            ram_waddr;
	wfa_pkg::ent_t            ram_wdata, rd_ent;
	logic [wfa_pkg::ENT_W-1:0] ram_rdata;

	wfa_ram #(
		.WIDTH(wfa_pkg::ENT_W),
		.DEPTH(wfa_pkg::MAX_EXTENTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(src_q),
		.rdata(ram_rdata)
	);

	assign rd_ent = wfa_pkg::ent_t'(ram_rdata);

	// derived values
	logic [wfa_pkg::REQ_W:0] rnd;
	logic [SW-1:0]           n_calc, lim_eff, nu;
	logic [SW:0]             free_end, pv_end, h_end;
	logic [IW-1:0]           scan_start, src_inc_wrap, i_idx, im1_idx;
	logic [CW-1:0]           cnt_dec;
	logic                    issue;

	assign rnd    = {1'b0, request_bytes} + (wfa_pkg::REQ_W + 1)'(wfa_pkg::UNIT_BYTES - 1);
	assign n_calc = SW'(rnd >> wfa_pkg::UNIT_SHIFT) + SW'(1);
	assign free_end = (SW + 1)'(free_address) - (SW + 1)'(1) + (SW + 1)'(free_units);
	assign lim_eff  = (lim_q > SW'(wfa_pkg::HEAP_UNITS)) ? SW'(wfa_pkg::HEAP_UNITS) : lim_q;
	assign nu       = (n_q < grow_q) ? grow_q : n_q;
	assign pv_end   = (SW + 1)'(pv_q.start) + (SW + 1)'(pv_q.size);
	assign h_end    = (SW + 1)'(h_q) + (SW + 1)'(u_q);
	assign scan_start   = ({1'b0, rover_q} < cnt_q) ? rover_q : '0;
	assign src_inc_wrap = (({1'b0, src_q} + CW'(1)) == cnt_q) ? '0 : src_q + IW'(1);
	assign i_idx    = ins_i_q[IW-1:0];
	assign im1_idx  = IW'(ins_i_q - CW'(1));
	assign cnt_dec  = cnt_q - CW'(1);

	// a read is issued only while a scan or shift has entries left
	assign issue = (rem_q != '0) &&
		((cmd.code == wfa_pkg::CMD_WSCAN) || (cmd.code == wfa_pkg::CMD_SHIFT) ||
		((cmd.code == wfa_pkg::CMD_ISCAN) && !stop_q));

	always_comb begin
		stat.op_free   = op_q;
		stat.free_ok   = free_ok_q;
		stat.scan_done = (rem_q == '0) && !rv_s1;
		stat.ins_done  = stop_q || ((rem_q == '0) && !rv_s1);
		stat.found     = found_q;
		stat.exact     = (best_sz_q == n_q);
		stat.grow_fail = (top_q > lim_eff) || (nu > (lim_eff - top_q));
		stat.ovl       = (pv_valid_q && (pv_end > (SW + 1)'(h_q))) ||
			(nx_valid_q && (h_end > (SW + 1)'(nx_q.start)));
		stat.mp        = pv_valid_q && (pv_end == (SW + 1)'(h_q));
		stat.mn        = nx_valid_q && (h_end == (SW + 1)'(nx_q.start));
		stat.full      = (cnt_q >= CW'(wfa_pkg::MAX_EXTENTS));
		stat.out_free  = !out_valid_q || !out_stall;
	end

	// table write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = i_idx;
		ram_wdata = '{start: h_q, size: u_q};
		case (cmd.code)
			wfa_pkg::CMD_TAKE_CUT: begin
				ram_we    = 1'b1;
				ram_waddr = best_idx_q;
				ram_wdata = '{start: best_start_q, size: best_sz_q - n_q};
			end
			wfa_pkg::CMD_MERGE_BOTH: begin
				ram_we    = 1'b1;
				ram_waddr = im1_idx;
				ram_wdata = '{start: pv_q.start, size: pv_q.size + u_q + nx_q.size};
			end
			wfa_pkg::CMD_MERGE_PREV: begin
				ram_we    = 1'b1;
				ram_waddr = im1_idx;
				ram_wdata = '{start: pv_q.start, size: pv_q.size + u_q};
			end
			wfa_pkg::CMD_MERGE_NEXT: begin
				ram_we    = 1'b1;
				ram_wdata = '{start: h_q, size: nx_q.size + u_q};
			end
			wfa_pkg::CMD_UP_FIN: begin
				ram_we = 1'b1;
			end
			wfa_pkg::CMD_SHIFT: begin
				ram_we    = rv_s1;
				ram_waddr = shift_up_q ? idx_s1 + IW'(1) : idx_s1 - IW'(1);
				ram_wdata = rd_ent;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q       <= SW'(wfa_pkg::HEAP_UNITS);
			grow_q      <= SW'(wfa_pkg::GROW_DEFAULT);
			top_q       <= '0;
			cnt_q       <= '0;
			rover_q     <= '0;
			rem_q       <= '0;
			op_q        <= 1'b0;
			free_ok_q   <= 1'b0;
			found_q     <= 1'b0;
			pv_valid_q  <= 1'b0;
			nx_valid_q  <= 1'b0;
			stop_q      <= 1'b0;
			shift_up_q  <= 1'b0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == wfa_pkg::CFG_HEAP_LIMIT) lim_q <= cfg_data;
				if (cfg_index == wfa_pkg::CFG_GROW_MIN)   grow_q <= cfg_data;
			end
			rv_s1 <= issue;
			if (issue) rem_q <= rem_q - CW'(1);
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (cmd.code)
				wfa_pkg::CMD_ACCEPT: begin
					op_q      <= op;
					free_ok_q <= (free_address != '0) && (free_units != '0) &&
						(free_end <= (SW + 1)'(top_q));
				end
				wfa_pkg::CMD_ISTART, wfa_pkg::CMD_GSTART: begin
					rem_q      <= cnt_q;
					stop_q     <= 1'b0;
					pv_valid_q <= 1'b0;
					nx_valid_q <= 1'b0;
				end
				wfa_pkg::CMD_WSTART: begin
					rem_q   <= cnt_q;
					found_q <= 1'b0;
				end
				wfa_pkg::CMD_GROW_COMMIT: begin
					top_q   <= top_q + u_q;
					rem_q   <= cnt_q;
					found_q <= 1'b0;
				end
				wfa_pkg::CMD_WSCAN: begin
					if (rv_s1 && (rd_ent.size >= n_q) &&
						(!found_q || (rd_ent.size > best_sz_q))) begin
						found_q <= 1'b1;
					end
				end
				wfa_pkg::CMD_ISCAN: begin
					if (rv_s1 && !stop_q) begin
						if (rd_ent.start <= h_q) begin
							pv_valid_q <= 1'b1;
						end else begin
							nx_valid_q <= 1'b1;
							stop_q     <= 1'b1;
						end
					end
				end
				wfa_pkg::CMD_TAKE_EXACT: begin
					rem_q      <= cnt_q - CW'(best_idx_q) - CW'(1);
					shift_up_q <= 1'b0;
				end
				wfa_pkg::CMD_TAKE_CUT: begin
					rover_q <= best_idx_q;
				end
				wfa_pkg::CMD_MERGE_BOTH: begin
					rem_q      <= cnt_q - ins_i_q - CW'(1);
					shift_up_q <= 1'b0;
				end
				wfa_pkg::CMD_MERGE_PREV: begin
					rover_q <= (ins_i_q < cnt_q) ? i_idx : '0;
				end
				wfa_pkg::CMD_MERGE_NEXT: begin
					rover_q <= i_idx;
				end
				wfa_pkg::CMD_UP_START: begin
					rem_q      <= cnt_q - ins_i_q;
					shift_up_q <= 1'b1;
				end
				wfa_pkg::CMD_UP_FIN: begin
					cnt_q   <= cnt_q + CW'(1);
					rover_q <= i_idx;
				end
				wfa_pkg::CMD_RM_FIN: begin
					cnt_q   <= cnt_dec;
					rover_q <= (tgt_q < cnt_dec) ? tgt_q[IW-1:0] : '0;
				end
				wfa_pkg::CMD_PUBLISH: begin
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= src_q;
		end
		case (cmd.code)
			wfa_pkg::CMD_ACCEPT: begin
				n_q <= n_calc;
				h_q <= free_address - AW'(1);
				u_q <= free_units;
			end
			wfa_pkg::CMD_RES_OK: begin
				res_pay_q <= '0;
				res_st_q  <= wfa_pkg::STATUS_OK;
			end
			wfa_pkg::CMD_OOM: begin
				res_pay_q <= '0;
				res_st_q  <= wfa_pkg::STATUS_OOM;
			end
			wfa_pkg::CMD_FULL: begin
				res_pay_q <= '0;
				res_st_q  <= wfa_pkg::STATUS_FULL;
			end
			wfa_pkg::CMD_ISTART: begin
				src_q   <= '0;
				ins_i_q <= '0;
			end
			wfa_pkg::CMD_GSTART: begin
				src_q   <= '0;
				ins_i_q <= '0;
				h_q     <= top_q[AW-1:0];
				u_q     <= nu;
			end
			wfa_pkg::CMD_WSTART, wfa_pkg::CMD_GROW_COMMIT: begin
				src_q <= scan_start;
			end
			wfa_pkg::CMD_WSCAN: begin
				if (issue) src_q <= src_inc_wrap;
				if (rv_s1 && (rd_ent.size >= n_q) &&
					(!found_q || (rd_ent.size > best_sz_q))) begin
					best_sz_q    <= rd_ent.size;
					best_start_q <= rd_ent.start;
					best_idx_q   <= idx_s1;
				end
			end
			wfa_pkg::CMD_ISCAN: begin
				if (issue) src_q <= src_q + IW'(1);
				if (rv_s1 && !stop_q) begin
					if (rd_ent.start <= h_q) begin
						pv_q    <= rd_ent;
						ins_i_q <= CW'(idx_s1) + CW'(1);
					end else begin
						nx_q <= rd_ent;
					end
				end
			end
			wfa_pkg::CMD_SHIFT: begin
				if (issue) src_q <= shift_up_q ? src_q - IW'(1) : src_q + IW'(1);
			end
			wfa_pkg::CMD_TAKE_EXACT: begin
				res_pay_q <= best_start_q + AW'(1);
				res_st_q  <= wfa_pkg::STATUS_OK;
				src_q     <= best_idx_q + IW'(1);
				tgt_q     <= CW'(best_idx_q);
			end
			wfa_pkg::CMD_TAKE_CUT: begin
				// tail cut: header sits at start + (size - n)
				res_pay_q <= AW'(SW'(best_start_q) + best_sz_q - n_q + SW'(1));
				res_st_q  <= wfa_pkg::STATUS_OK;
			end
			wfa_pkg::CMD_MERGE_BOTH: begin
				src_q <= i_idx + IW'(1);
				tgt_q <= ins_i_q;
			end
			wfa_pkg::CMD_UP_START: begin
				src_q <= IW'(cnt_q - CW'(1));
			end
			wfa_pkg::CMD_PUBLISH: begin
				out_pay_q <= res_pay_q;
				out_st_q  <= res_st_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid       = out_valid_q;
	assign payload_address = out_pay_q;
	assign status          = out_st_q;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(wfa_pkg::MAX_EXTENTS))
		else $error("extent count past table depth");
	a_rover_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rover_q == '0) || ({1'b0, rover_q} < cnt_q))
		else $error("rover past extent count");
	a_top_max: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= SW'(wfa_pkg::HEAP_UNITS))
		else $error("heap top past heap size");
	a_cut_larger: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == wfa_pkg::CMD_TAKE_CUT) |-> (found_q && (best_sz_q > n_q)))
		else $error("tail cut from an extent that does not exceed the request");

endmodule

>>> rtl/worst_fit_extent_allocator_top.sv
// Sequence: an alloc that fits runs a worst-fit scan over the free extents;
// an exact fit adds a down-shift of the table; a growth adds an address scan,
// an up- or down-shift where needed, and a rescan.
// A free runs an address scan and, where needed, an up- or down-shift of the table.
// Throughput: one beat at a time, set by the sweeps over the table RAM.
// Reset (arst_n low, asynchronous): table empty, rover 0, heap top 0,
// heap limit 65536 units, minimum growth 1024 units; RAM contents untouched.
`timescale 1ns / 1ps
module worst_fit_extent_allocator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [wfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wfa_pkg::CFG_W-1:0]      cfg_data,
	// request beat
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [wfa_pkg::REQ_W-1:0]      request_bytes,
	input  logic [wfa_pkg::ADDR_W-1:0]     free_address,
	input  logic [wfa_pkg::SIZE_W-1:0]     free_units,
	// result beat
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [wfa_pkg::ADDR_W-1:0]     payload_address,
	output logic [wfa_pkg::ST_W-1:0]       status
);

	// controller sequences scans/shifts; datapath owns table, heap and results
	wfa_pkg::dp_cmd_t  cmd;
	wfa_pkg::dp_stat_t stat;

	wfa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.stat    (stat)
	);

	// the result register lets the next request start while a beat waits
	wfa_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op             (op),
		.request_bytes  (request_bytes),
		.free_address   (free_address),
		.free_units     (free_units),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.payload_address(payload_address),
		.status         (status),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule
